>>> hdl/rrq_pkg.sv
// Package for the round-robin run queue scheduler.
// Holds sizes, operation codes and the thread number type; no dependencies.
package rrq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TID_W       = 4;
    localparam int FLAG_W      = 2 ** TID_W;
    localparam int QDEPTH      = 16;
    localparam int QADDR_W     = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int FUNC_W      = 2;

    typedef logic [TID_W-1:0]   t_tid;
    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [FLAG_W-1:0]  t_flags;
    typedef logic [QADDR_W-1:0] t_qaddr;
    typedef logic [QCNT_W-1:0]  t_qcnt;

    localparam t_func FUNC_SCHEDULE = 2'd0;
    localparam t_func FUNC_SWITCH   = 2'd1;
    localparam t_func FUNC_EXIT     = 2'd2;

endpackage

>>> hdl/rrq_in_if.sv
// Request channel of the scheduler: valid, ready and one operation beat.
// Depends on rrq_pkg.
interface rrq_in_if;
    import rrq_pkg::*;

    logic  valid;
    logic  ready;
    t_func func;
    t_tid  thread_id;

    modport source (output valid, output func, output thread_id, input ready);
    modport sink (input valid, input func, input thread_id, output ready);
endinterface

>>> hdl/rrq_out_if.sv
// Result channel of the scheduler: valid, ready and one result beat.
// Depends on rrq_pkg.
interface rrq_out_if;
    import rrq_pkg::*;

    logic valid;
    logic ready;
    logic accepted;
    logic current_valid;
    t_tid current_id;

    modport source (output valid, output accepted, output current_valid,
                    output current_id, input ready);
    modport sink (input valid, input accepted, input current_valid,
                  input current_id, output ready);
endinterface

>>> hdl/rrq_queue_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module rrq_queue_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hdl/round_robin_run_queue_scheduler_core.sv
// Round-robin run queue scheduler: queue RAM, thread flags and control.
// A request beat is taken in S_IDLE; S_EXEC registers its result beat once the output register is empty or being taken.
// A new request is taken only after the last one has executed. The head is read through the queue RAM's
// registered read port when a request is taken; the update and write-back follow in S_EXEC.
// Reset: synchronous, active low; clears pointers, flags, current thread and idle thread.
// The queue RAM is not cleared; only entries that were pushed are ever popped.
module round_robin_run_queue_scheduler_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  rrq_pkg::t_tid     i_cfg_wdata,
    rrq_in_if.sink            i_req,
    rrq_out_if.source         o_rsp
);
    import rrq_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state r_state;
    t_func  r_func;
    t_tid   r_tid;
    t_tid   r_idle;
    t_qaddr r_head, n_head;
    t_qaddr r_tail, n_tail;
    t_qcnt  r_count, n_count;
    t_flags r_running, n_running;
    t_flags r_queued, n_queued;
    t_tid   r_cur, n_cur;
    logic   r_present, n_present;
    logic   n_acc;

    logic   r_out_valid;
    logic   r_out_acc;
    logic   r_out_cv;
    t_tid   r_out_id;

    logic   wr_en;
    t_qaddr wr_addr;
    t_tid   wr_data;
    t_tid   rd_data;
    logic   req_fire;
    logic   exec_fire;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign exec_fire   = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    rrq_queue_ram #(
        .DEPTH (QDEPTH),
        .WIDTH (TID_W)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (req_fire),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    always_comb begin
        logic have_new;
        logic resume;
        t_tid new_t;

        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_running = r_running;
        n_queued  = r_queued;
        n_cur     = r_cur;
        n_present = r_present;
        n_acc     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_tail;
        wr_data   = r_tid;
        have_new  = 1'b0;
        resume    = 1'b0;
        new_t     = rd_data;

        unique case (r_func)
            FUNC_SCHEDULE: begin
                if ((int'(r_tid) < MAX_THREADS) && !r_queued[r_tid] && !r_running[r_tid]
                        && (r_count < QCNT_W'(QDEPTH))) begin
                    wr_en          = exec_fire;
                    n_tail         = r_tail + 1'b1;
                    n_count        = r_count + 1'b1;
                    n_queued[r_tid] = 1'b1;
                    n_acc          = 1'b1;
                end
            end
            FUNC_SWITCH: begin
                have_new = (r_count != '0);
                if (have_new) begin
                    n_head  = r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
                if (r_present && r_running[r_cur]) begin
                    if (!have_new) begin
                        resume = 1'b1;
                    end else begin
                        n_running[r_cur] = 1'b0;
                        if (r_cur != r_idle) begin
                            wr_en           = exec_fire;
                            wr_data         = r_cur;
                            n_tail          = r_tail + 1'b1;
                            n_count         = n_count + 1'b1;
                            n_queued[r_cur] = 1'b1;
                        end else begin
                            n_queued[r_cur] = 1'b0;
                        end
                    end
                end
                if (!resume) begin
                    if (!have_new) begin
                        new_t = r_idle;
                    end
                    n_cur            = new_t;
                    n_present        = 1'b1;
                    n_queued[new_t]  = 1'b0;
                    n_running[new_t] = 1'b1;
                    n_acc            = 1'b1;
                end
            end
            FUNC_EXIT: begin
                n_present = 1'b0;
                n_cur     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
        end else if (i_cfg_we) begin
            r_idle <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func <= i_req.func;
            r_tid  <= i_req.thread_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_running   <= '0;
            r_queued    <= '0;
            r_cur       <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_acc   <= 1'b0;
            r_out_cv    <= 1'b0;
            r_out_id    <= '0;
        end else begin
            if (o_rsp.ready && !exec_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state     <= S_IDLE;
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_count     <= n_count;
                        r_running   <= n_running;
                        r_queued    <= n_queued;
                        r_cur       <= n_cur;
                        r_present   <= n_present;
                        r_out_valid <= 1'b1;
                        r_out_acc   <= n_acc;
                        r_out_cv    <= n_present;
                        r_out_id    <= n_present ? n_cur : '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.accepted      = r_out_acc;
    assign o_rsp.current_valid = r_out_cv;
    assign o_rsp.current_id    = r_out_id;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("Queue count exceeds the queue depth.");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QADDR_W'(r_tail - r_head) == r_count[QADDR_W-1:0])
        else $error("Queue count disagrees with head and tail pointers.");

    a_switch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_func == FUNC_SWITCH) && n_acc)
            |=> (r_present && r_running[r_cur]))
        else $error("Selected thread is not current and running after a switch.");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("Result beat appeared without an executed request.");
endmodule

>>> sim/round_robin_run_queue_scheduler_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_run_queue_scheduler_core.
// A tracker class predicts every result beat from its own copy of the scheduler state.
// Depends on rrq_pkg, rrq_in_if, rrq_out_if and the core itself.
module round_robin_run_queue_scheduler_core_tb;
    import rrq_pkg::*;

    localparam t_func FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic accepted;
        logic cur_valid;
        t_tid cur_id;
    } t_sched_result;

    class run_queue_tracker;
        t_tid          ring [QDEPTH];
        t_qaddr        head;
        t_qaddr        tail;
        t_qcnt         count;
        t_flags        running;
        t_flags        queued;
        t_tid          cur;
        logic          cur_ok;
        t_tid          idle;
        t_sched_result pending_results [$];
        int            mismatches;

        function new();
            head       = '0;
            tail       = '0;
            count      = '0;
            running    = '0;
            queued     = '0;
            cur        = '0;
            cur_ok     = 1'b0;
            idle       = '0;
            mismatches = 0;
        endfunction

        function void push_thread(t_tid t);
            if (count >= QDEPTH) return;
            ring[tail] = t;
            tail++;
            count++;
            queued[t] = 1'b1;
        endfunction

        function void note_request(t_func f, t_tid t);
            logic          acc;
            logic          have_new;
            logic          resume;
            t_tid          nt;
            t_sched_result r;
            acc      = 1'b0;
            have_new = 1'b0;
            resume   = 1'b0;
            nt       = '0;
            case (f)
                FUNC_SCHEDULE: begin
                    if (int'(t) < MAX_THREADS && !queued[t] && !running[t] &&
                        count < QDEPTH) begin
                        push_thread(t);
                        acc = 1'b1;
                    end
                end
                FUNC_SWITCH: begin
                    if (count != 0) begin
                        nt = ring[head];
                        head++;
                        count--;
                        have_new = 1'b1;
                    end
                    if (cur_ok && running[cur]) begin
                        if (!have_new) begin
                            resume = 1'b1;
                        end else begin
                            running[cur] = 1'b0;
                            if (cur != idle) push_thread(cur);
                            else queued[cur] = 1'b0;
                        end
                    end
                    if (!resume) begin
                        if (!have_new) nt = idle;
                        cur         = nt;
                        cur_ok      = 1'b1;
                        queued[nt]  = 1'b0;
                        running[nt] = 1'b1;
                        acc         = 1'b1;
                    end
                end
                FUNC_EXIT: begin
                    cur_ok = 1'b0;
                    cur    = '0;
                end
                default: ;
            endcase
            r.accepted  = acc;
            r.cur_valid = cur_ok;
            r.cur_id    = cur_ok ? cur : '0;
            pending_results.push_back(r);
        endfunction

        function void log_mismatch(string what, t_sched_result want, t_sched_result got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected acc=%0b cur_valid=%0b cur_id=%0d, ",
                          "got acc=%0b cur_valid=%0b cur_id=%0d"},
                         what, want.accepted, want.cur_valid, want.cur_id,
                         got.accepted, got.cur_valid, got.cur_id);
        endfunction

        function void check_result(logic acc, logic cv, t_tid id);
            t_sched_result want;
            t_sched_result got;
            got.accepted  = acc;
            got.cur_valid = cv;
            got.cur_id    = id;
            if (pending_results.size() == 0) begin
                log_mismatch("result beat with no request pending", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted || got.cur_valid !== want.cur_valid ||
                got.cur_id !== want.cur_id)
                log_mismatch("result mismatch", want, got);
        endfunction

        function t_flags stuck_threads();
            t_flags s;
            s = running & ~queued;
            if (cur_ok) s[cur] = 1'b0;
            return s;
        endfunction

        function int free_thread();
            t_flags f;
            int     s;
            f = ~(running | queued);
            if (f == '0) return -1;
            s = $urandom_range(FLAG_W - 1);
            for (int k = 0; k < FLAG_W; k++)
                if (f[(s + k) % FLAG_W]) return (s + k) % FLAG_W;
            return -1;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_tid cfg_wdata;
    logic hold_rsp = 1'b0;
    int   src_idle_pct = 25;
    int   snk_idle_pct = 74;
    int   req_beats = 0;

    run_queue_tracker tracker = new();

    rrq_in_if  req_if ();
    rrq_out_if rsp_if ();

    round_robin_run_queue_scheduler_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("round_robin_run_queue_scheduler_core test failed");
        $finish;
    end

    task automatic send_op(input t_func f, input t_tid t);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.thread_id <= t;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        tracker.note_request(f, t);
        req_beats++;
    endtask

    task automatic random_op();
        int   r;
        int   pick;
        t_tid t;
        r = $urandom_range(99);
        t = t_tid'($urandom_range(FLAG_W - 1));
        if (r < 45) begin
            pick = tracker.free_thread();
            if (pick >= 0 && $urandom_range(9) < 8) t = t_tid'(pick);
            send_op(FUNC_SCHEDULE, t);
        end else if (r < 92) begin
            send_op(FUNC_SWITCH, t);
        end else if (r < 95) begin
            send_op(FUNC_EXIT, t);
        end else begin
            send_op(FUNC_UNUSED, t);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_idle(input t_tid v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        tracker.idle = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // The receiver stops taking beats for a long stretch so the core backs up.
    initial begin
        wait (req_beats >= 80);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (200) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            tracker.check_result(rsp_if.accepted, rsp_if.current_valid, rsp_if.current_id);
    end

    initial begin
        t_flags stuck;
        t_tid   next_idle;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_SCHEDULE;
        req_if.thread_id <= '0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        rst_n            <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // With an empty queue and no current thread, the idle thread takes over, then resumes.
        send_op(FUNC_SWITCH, 4'd0);
        send_op(FUNC_SWITCH, 4'd15);
        send_op(FUNC_SCHEDULE, 4'd15);
        send_op(FUNC_SCHEDULE, 4'd15);
        send_op(FUNC_SCHEDULE, 4'd0);
        send_op(FUNC_UNUSED, 4'd15);
        send_op(FUNC_SWITCH, 4'd0);
        send_op(FUNC_SWITCH, 4'd0);
        send_op(FUNC_SCHEDULE, 4'd3);
        send_op(FUNC_SWITCH, 4'd0);
        send_op(FUNC_EXIT, 4'd0);
        send_op(FUNC_EXIT, 4'd15);
        send_op(FUNC_SWITCH, 4'd0);
        send_op(FUNC_SCHEDULE, 4'd3);
        send_op(FUNC_SCHEDULE, 4'd0);
        send_op(FUNC_SWITCH, 4'd0);

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 74 : 0;
            snk_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 25 : 0;
            for (int chunk = 0; chunk < 10; chunk++) begin
                drain_results();
                // An exited thread keeps its running flag; naming it the idle thread frees it.
                stuck = tracker.stuck_threads();
                next_idle = t_tid'($urandom_range(FLAG_W - 1));
                if (chunk == 0) begin
                    next_idle = (phase == 1) ? '0 : '1;
                end else if (stuck != '0) begin
                    for (int i = FLAG_W - 1; i >= 0; i--)
                        if (stuck[i]) next_idle = t_tid'(i);
                end
                write_idle(next_idle);
                repeat (38) random_op();
            end
        end

        drain_results();
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("round_robin_run_queue_scheduler_core test passed");
        else
            $display("round_robin_run_queue_scheduler_core test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rrq_pkg.sv
hdl/rrq_in_if.sv
hdl/rrq_out_if.sv
hdl/rrq_queue_ram.sv
hdl/round_robin_run_queue_scheduler_core.sv
sim/round_robin_run_queue_scheduler_core_tb.sv
